// ===== src/assert_macros.svh =====
// Assertion macros shared by the texture sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/bts_pkg.sv =====
// Package with widths, commands and pipeline types of the texture sampler.
package bts_pkg;

    localparam int MAX_TEXELS_DEF = 65536;
    localparam int SIZE_W = 9;
    localparam int COORD_W = 17;
    localparam int CHAN_W = 8;
    localparam int TEXEL_W = 24;
    localparam int FRAC_W = 16;
    localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } texel_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] res;
        if (s < 9'd2)
            res = 9'd2;
        else if (s > 9'd256)
            res = 9'd256;
        else
            res = s;
        return res;
    endfunction

endpackage

// ===== src/bts_addr.sv =====
// Address stages: clamp, scale coordinates, form the base texel addresses of the two rows.
module bts_addr
    import bts_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [COORD_W-1:0]  coord_u,
    input  logic [COORD_W-1:0]  coord_v,
    input  logic [SIZE_W-1:0]   width,
    input  logic [SIZE_W-1:0]   height,
    output logic                out_valid,
    output logic [ADDR_W:0]     addr00,
    output logic [ADDR_W:0]     addr01,
    output logic [FRAC_W-1:0]   fu,
    output logic [FRAC_W-1:0]   fv
);
    logic [COORD_W-1:0] u_c, v_c;
    logic [SIZE_W-1:0]  w_c, h_c;
    logic               v1_reg;
    logic [24:0]        up_reg, vp_reg;
    logic [SIZE_W-1:0]  w1_reg;
    logic               v2_reg;
    logic [ADDR_W:0]    a00_reg, a01_reg;
    logic [FRAC_W-1:0]  fu_reg, fv_reg;
    logic [17:0]        base_row;
    logic [17:0]        a00_next, a01_next;

    always_comb
    begin
        w_c = clamp_size(width);
        h_c = clamp_size(height);
        u_c = (coord_u > COORD_ONE) ? COORD_ONE : coord_u;
        v_c = COORD_ONE - ((coord_v > COORD_ONE) ? COORD_ONE : coord_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up_reg <= 25'(u_c * 8'(w_c - 9'd2));
            vp_reg <= 25'(v_c * 8'(h_c - 9'd2));
            w1_reg <= w_c;
        end
    end

    always_comb
    begin
        base_row = 18'(vp_reg[23:16]) * 18'(w1_reg);
        a00_next = base_row + 18'(up_reg[24:16]);
        a01_next = a00_next + 18'(w1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a00_reg <= (ADDR_W + 1)'(a00_next);
            a01_reg <= (ADDR_W + 1)'(a01_next);
            fu_reg  <= up_reg[15:0];
            fv_reg  <= vp_reg[15:0];
        end
    end

    assign out_valid = v2_reg;
    assign addr00 = a00_reg;
    assign addr01 = a01_reg;
    assign fu = fu_reg;
    assign fv = fv_reg;
endmodule

// ===== src/bts_store.sv =====
// Texel store in four copies, one per neighbor read, with registered reads.
module bts_store
    import bts_pkg::*;
#(
    parameter int MAX_TEXELS = MAX_TEXELS_DEF,
    parameter int ADDR_W = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  texel_t             wr_data,
    input  logic               in_valid,
    input  logic [ADDR_W:0]    addr00,
    input  logic [ADDR_W:0]    addr01,
    input  logic [FRAC_W-1:0]  fu,
    input  logic [FRAC_W-1:0]  fv,
    output logic               out_valid,
    output texel_t             c00,
    output texel_t             c01,
    output texel_t             c10,
    output texel_t             c11,
    output logic [FRAC_W-1:0]  fu_out,
    output logic [FRAC_W-1:0]  fv_out
);
    localparam int AW1 = ADDR_W + 2;
    texel_t mem0 [MAX_TEXELS];
    texel_t mem1 [MAX_TEXELS];
    texel_t mem2 [MAX_TEXELS];
    texel_t mem3 [MAX_TEXELS];

    logic [AW1-1:0] a0, a1, a2, a3;
    logic [3:0]     ok_reg;
    texel_t         r0_reg, r1_reg, r2_reg, r3_reg;
    logic           v_reg;
    logic [FRAC_W-1:0] fu_reg, fv_reg;
    logic wr_ok;
    logic              wv1_reg, wv2_reg;
    logic [ADDR_W-1:0] wa1_reg, wa2_reg;
    texel_t            wd1_reg, wd2_reg;

    assign a0 = AW1'(addr00);
    assign a1 = AW1'(addr01);
    assign a2 = AW1'(addr00) + AW1'(1);
    assign a3 = AW1'(addr01) + AW1'(1);
    assign wr_ok = wr_en && (ADDR_W'(MAX_TEXELS - 1) >= wr_addr);

    // Delay writes to the read stage so that requests act on the store in order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv1_reg <= 1'b0;
            wv2_reg <= 1'b0;
        end
        else if (en)
        begin
            wv1_reg <= wr_ok;
            wv2_reg <= wv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wa1_reg <= wr_addr;
            wa2_reg <= wa1_reg;
            wd1_reg <= wr_data;
            wd2_reg <= wd1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && wv2_reg)
        begin
            mem0[wa2_reg] <= wd2_reg;
            mem1[wa2_reg] <= wd2_reg;
            mem2[wa2_reg] <= wd2_reg;
            mem3[wa2_reg] <= wd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= mem0[a0[ADDR_W-1:0]];
            r1_reg <= mem1[a1[ADDR_W-1:0]];
            r2_reg <= mem2[a2[ADDR_W-1:0]];
            r3_reg <= mem3[a3[ADDR_W-1:0]];
            ok_reg <= {a3 < AW1'(MAX_TEXELS), a2 < AW1'(MAX_TEXELS),
                       a1 < AW1'(MAX_TEXELS), a0 < AW1'(MAX_TEXELS)};
            fu_reg <= fu;
            fv_reg <= fv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    assign out_valid = v_reg;
    assign c00 = ok_reg[0] ? r0_reg : '0;
    assign c01 = ok_reg[1] ? r1_reg : '0;
    assign c10 = ok_reg[2] ? r2_reg : '0;
    assign c11 = ok_reg[3] ? r3_reg : '0;
    assign fu_out = fu_reg;
    assign fv_out = fv_reg;
endmodule

// ===== src/bts_blend.sv =====
// Blend stages: weights, per-channel products, sum and round.
module bts_blend
    import bts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  texel_t             c00,
    input  texel_t             c01,
    input  texel_t             c10,
    input  texel_t             c11,
    input  logic [FRAC_W-1:0]  fu,
    input  logic [FRAC_W-1:0]  fv,
    output logic               out_valid,
    output texel_t             result
);
    logic [16:0] wu0, wv0;
    logic [32:0] w_reg [4];
    texel_t      c_reg [4];
    logic        v1_reg, v2_reg, v3_reg;
    logic [40:0] p_reg [4][3];
    texel_t      res_reg;
    logic [42:0] sum [3];
    logic [42:0] rnd [3];

    assign wu0 = COORD_ONE - 17'(fu);
    assign wv0 = COORD_ONE - 17'(fv);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0] <= 33'(wu0 * wv0);
            w_reg[1] <= 33'(wu0 * 17'(fv));
            w_reg[2] <= 33'(17'(fu) * wv0);
            w_reg[3] <= 33'(17'(fu) * 17'(fv));
            c_reg[0] <= c00;
            c_reg[1] <= c01;
            c_reg[2] <= c10;
            c_reg[3] <= c11;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k][0] <= 41'(w_reg[k] * c_reg[k].r);
                p_reg[k][1] <= 41'(w_reg[k] * c_reg[k].g);
                p_reg[k][2] <= 41'(w_reg[k] * c_reg[k].b);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = 43'(p_reg[0][ch]) + 43'(p_reg[1][ch]) + 43'(p_reg[2][ch])
                    + 43'(p_reg[3][ch]);
            rnd[ch] = sum[ch] + 43'h0_8000_0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.r <= rnd[0][39:32];
            res_reg.g <= rnd[1][39:32];
            res_reg.b <= rnd[2][39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign result = res_reg;
endmodule

// ===== src/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler.
// Usage:
//   s_axis carries requests. tuser is the command: low writes the texel in
//   tdata to texel_address, high samples at coord_u/coord_v.
//   m_axis returns one filtered RGB result per sample request; writes
//   return nothing.
//   A sample request passes two address stages, one memory read and three
//   blend stages on its way to the result. One request per cycle is taken
//   when the receiver keeps up; the four-copy texel store serves all four
//   neighbor reads in the same cycle.
//   When m_axis stalls with a valid result, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 width,
//   1 height); the user must write only while idle, the block does not enforce it.
//   Reset clears pipeline valids and sets both sizes to 256; texel
//   contents are undefined until written, with no clearing pass.
`include "assert_macros.svh"
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_TEXELS = MAX_TEXELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: texel_address[15:0], texel_red[23:16], texel_green[31:24],
    // texel_blue[39:32], coord_u[56:40], coord_v[73:57], zero fill to 80
    input  logic [79:0]         s_axis_tdata,
    // tuser: command
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: sample_red[7:0], sample_green[15:8], sample_blue[23:16]
    output logic [23:0]         m_axis_tdata,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data
);
    localparam int ADDR_W = (MAX_TEXELS > 65536) ? $clog2(MAX_TEXELS) : 16;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic en, acc, smp;
    logic stall;
    logic a_valid, s_valid, b_valid;
    logic [ADDR_W:0] addr00, addr01;
    logic [FRAC_W-1:0] fu_a, fv_a, fu_s, fv_s;
    texel_t c00, c01, c10, c11, wr_data, result;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign stall = m_axis_tvalid && !m_axis_tready;
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign smp = acc && (s_axis_tuser == CMD_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign wr_data.r = s_axis_tdata[23:16];
    assign wr_data.g = s_axis_tdata[31:24];
    assign wr_data.b = s_axis_tdata[39:32];

    bts_addr #(.ADDR_W(ADDR_W)) u_addr (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(smp),
        .coord_u(s_axis_tdata[56:40]), .coord_v(s_axis_tdata[73:57]),
        .width(width_reg), .height(height_reg),
        .out_valid(a_valid), .addr00(addr00), .addr01(addr01),
        .fu(fu_a), .fv(fv_a)
    );

    bts_store #(.MAX_TEXELS(MAX_TEXELS), .ADDR_W(ADDR_W)) u_store (
        .clk(clk), .rst_n(rst_n), .en(en),
        .wr_en(acc && (s_axis_tuser == CMD_WRITE)),
        .wr_addr(ADDR_W'(s_axis_tdata[15:0])), .wr_data(wr_data),
        .in_valid(a_valid), .addr00(addr00), .addr01(addr01),
        .fu(fu_a), .fv(fv_a), .out_valid(s_valid),
        .c00(c00), .c01(c01), .c10(c10), .c11(c11),
        .fu_out(fu_s), .fv_out(fv_s)
    );

    bts_blend u_blend (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid),
        .c00(c00), .c01(c01), .c10(c10), .c11(c11),
        .fu(fu_s), .fv(fv_s), .out_valid(b_valid), .result(result)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata = {result.b, result.g, result.r};

    `ASSERT_NEXT(a_hold_valid, clk, rst_n, stall, m_axis_tvalid, "result dropped in stall")
    `ASSERT_NEXT(a_hold_data, clk, rst_n, stall, $stable(m_axis_tdata), "result changed in stall")
    `ASSERT_IMPLY(a_ready_rule, clk, rst_n, 1'b1, s_axis_tready == !stall, "ready out of step")
endmodule
